// File: hw/rtl/ufd_pkg.sv
// shared types and constants for the fixed-width decimal formatter
// used by ufd_front, ufd_queue, ufd_back and the top level

package ufd_pkg;

  localparam int BIN_BITS   = 32;
  localparam int WIDTH_BITS = 6;
  localparam int DEC_DIGITS = 10;
  localparam int BCD_BITS   = 4 * DEC_DIGITS;
  localparam int CHAR_BITS  = 6;
  localparam int QDEPTH     = 2;

  localparam logic [CHAR_BITS-1:0] ASCII_ZERO = 6'h30;

  // one conversion job, width already clamped and nonzero
  typedef struct packed {
    logic [BIN_BITS-1:0]   value;
    logic [WIDTH_BITS-1:0] width;
  } job_t;

  // write side of the job queue
  typedef struct packed {
    logic valid;
    job_t job;
  } push_t;

  // queue occupancy flags
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: hw/rtl/ufd_front.sv
// front end: accepts input transfers, clamps the width, drops empty jobs
// depends on ufd_pkg

module ufd_front #(
  parameter int MAX_WIDTH = 32
) (
  input  logic [ufd_pkg::BIN_BITS-1:0]   in_value,
  input  logic [ufd_pkg::WIDTH_BITS-1:0] in_field_width,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  ufd_pkg::q_stat_t               q_stat,
  output ufd_pkg::push_t                 push
);

  logic                           clamp;
  logic [ufd_pkg::WIDTH_BITS-1:0] width_c;

  // clamp width to the configured maximum
  assign clamp   = {1'b0, in_field_width} > (ufd_pkg::WIDTH_BITS+1)'(MAX_WIDTH);
  assign width_c = clamp ? ufd_pkg::WIDTH_BITS'(MAX_WIDTH) : in_field_width;

  // hold off input only when the queue has no room
  assign in_stall = q_stat.full;

  // zero-width jobs are accepted and discarded
  assign push.valid     = in_valid && !q_stat.full && (width_c != '0);
  assign push.job.value = in_value;
  assign push.job.width = width_c;

endmodule

// File: hw/rtl/ufd_queue.sv
// two-entry job queue between front end and conversion back end
// depends on ufd_pkg

module ufd_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  ufd_pkg::push_t   push,
  input  logic             pop,
  output ufd_pkg::job_t    head,
  output ufd_pkg::q_stat_t q_stat
);

  localparam int PW = $clog2(ufd_pkg::QDEPTH);

  ufd_pkg::job_t       mem_r [ufd_pkg::QDEPTH];
  logic [PW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]         cnt_r, cnt_nxt;
  logic                do_push, do_pop;

  assign q_stat.full  = (cnt_r == (PW+1)'(ufd_pkg::QDEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign head         = mem_r[rd_ptr_r];

  assign do_push = push.valid && !q_stat.full;
  assign do_pop  = pop && !q_stat.empty;

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(ufd_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(ufd_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.job;
    end
  end

endmodule

// File: hw/rtl/ufd_back.sv
// back end: bit-serial binary to bcd conversion, then one character per transfer
// depends on ufd_pkg

module ufd_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ufd_pkg::job_t                 head,
  input  ufd_pkg::q_stat_t              q_stat,
  output logic                          pop,
  output logic [ufd_pkg::CHAR_BITS-1:0] out_digit_char,
  output logic                          out_last_char,
  output logic                          out_valid,
  input  logic                          out_stall
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  localparam int CW = $clog2(ufd_pkg::BIN_BITS);

  logic [1:0]                      state_r, state_nxt;
  logic [ufd_pkg::BIN_BITS-1:0]    bin_r, bin_nxt;
  logic [ufd_pkg::BCD_BITS-1:0]    bcd_r, bcd_nxt;
  logic [ufd_pkg::BCD_BITS-1:0]    bcd_adj;
  logic [CW-1:0]                   cnt_r, cnt_nxt;
  logic [ufd_pkg::WIDTH_BITS-1:0]  pos_r, pos_nxt;
  logic                            ov_r, ov_nxt;
  logic [ufd_pkg::CHAR_BITS-1:0]   ch_r, ch_nxt;
  logic                            last_r, last_nxt;
  logic [3:0]                      dsel;
  logic                            slot_free;

  assign out_valid      = ov_r;
  assign out_digit_char = ch_r;
  assign out_last_char  = last_r;
  assign slot_free      = !ov_r || !out_stall;
  assign pop            = (state_r == ST_IDLE) && !q_stat.empty;

  // add-3 correction on every bcd digit
  always_comb begin
    for (int k = 0; k < ufd_pkg::DEC_DIGITS; k++) begin
      bcd_adj[k*4 +: 4] = (bcd_r[k*4 +: 4] >= 4'd5) ? bcd_r[k*4 +: 4] + 4'd3
                                                      : bcd_r[k*4 +: 4];
    end
  end

  // digit at the current position, zero above the tenth digit
  always_comb begin
    dsel = '0;
    for (int k = 0; k < ufd_pkg::DEC_DIGITS; k++) begin
      if (pos_r == ufd_pkg::WIDTH_BITS'(k)) begin
        dsel = bcd_r[k*4 +: 4];
      end
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    bin_nxt   = bin_r;
    bcd_nxt   = bcd_r;
    cnt_nxt   = cnt_r;
    pos_nxt   = pos_r;
    ov_nxt    = ov_r;
    ch_nxt    = ch_r;
    last_nxt  = last_r;
    if (ov_r && !out_stall) begin
      ov_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          bin_nxt   = head.value;
          bcd_nxt   = '0;
          cnt_nxt   = '0;
          pos_nxt   = head.width - 1'b1;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        bcd_nxt = {bcd_adj[ufd_pkg::BCD_BITS-2:0], bin_r[ufd_pkg::BIN_BITS-1]};
        bin_nxt = {bin_r[ufd_pkg::BIN_BITS-2:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(ufd_pkg::BIN_BITS - 1)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          ov_nxt   = 1'b1;
          ch_nxt   = ufd_pkg::ASCII_ZERO | {2'b00, dsel};
          last_nxt = (pos_r == '0);
          if (pos_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            pos_nxt = pos_r - 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    bin_r  <= bin_nxt;
    bcd_r  <= bcd_nxt;
    cnt_r  <= cnt_nxt;
    pos_r  <= pos_nxt;
    ch_r   <= ch_nxt;
    last_r <= last_nxt;
  end

endmodule

// File: hw/rtl/uint32_to_fixed_width_decimal.sv
// fixed-width decimal formatter top level: front end, job queue, back end
// each job passes through the job queue, the 32-step bcd shifter and then the output register,
//   which gives one character per cycle while out_stall is low; a new job is taken from the
//   queue only once the back end is idle again
// zero-width items produce nothing; two jobs may wait queued
// reset: synchronous active-low rst_n empties the queue and idles the back end

module uint32_to_fixed_width_decimal #(
  parameter int MAX_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [ufd_pkg::BIN_BITS-1:0]   in_value,
  input  logic [ufd_pkg::WIDTH_BITS-1:0] in_field_width,
  input  logic                           in_valid,
  output logic                           in_stall,
  output logic [ufd_pkg::CHAR_BITS-1:0]  out_digit_char,
  output logic                           out_last_char,
  output logic                           out_valid,
  input  logic                           out_stall
);

  ufd_pkg::push_t   push;
  ufd_pkg::q_stat_t q_stat;
  ufd_pkg::job_t    head;
  logic             pop;

  ufd_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .in_value       (in_value),
    .in_field_width (in_field_width),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .q_stat         (q_stat),
    .push           (push)
  );

  ufd_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .pop    (pop),
    .head   (head),
    .q_stat (q_stat)
  );

  ufd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .q_stat         (q_stat),
    .pop            (pop),
    .out_digit_char (out_digit_char),
    .out_last_char  (out_last_char),
    .out_valid      (out_valid),
    .out_stall      (out_stall)
  );

endmodule

// File: hw/rtl/ufd_checker.sv
// port-level checks for the fixed-width decimal formatter, bound to the top level
// depends on ufd_pkg

module ufd_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_stall,
  input logic [ufd_pkg::CHAR_BITS-1:0]  out_digit_char,
  input logic                           out_last_char,
  input logic                           out_valid,
  input logic                           out_stall
);

  // a stalled output transfer holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_digit_char) && $stable(out_last_char))
    else $error("output payload changed while stalled");

  // every character is an ascii decimal digit
  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_digit_char >= 6'd48) && (out_digit_char <= 6'd57))
    else $error("output character is not a decimal digit");

  // reset empties the output register
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // reset empties the job queue
  a_rst_in: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("input stalled after reset");

endmodule

bind uint32_to_fixed_width_decimal ufd_checker u_ufd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_digit_char (out_digit_char),
  .out_last_char  (out_last_char),
  .out_valid      (out_valid),
  .out_stall      (out_stall)
);
